[hdl/itoaf_pkg.sv]
// Shared codes, prefix types and character helpers for the integer to ASCII formatter.
// Used by integer_to_ascii_formatter_unit and its port checker; no dependencies.
package itoaf_pkg;

	localparam logic [2:0] ACT_SDEC = 3'd0;
	localparam logic [2:0] ACT_UDEC = 3'd1;
	localparam logic [2:0] ACT_HEXL = 3'd2;
	localparam logic [2:0] ACT_HEXU = 3'd3;
	localparam logic [2:0] ACT_PTR  = 3'd4;

	localparam int ACT_W   = 3;
	localparam int VALUE_W = 64;
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 5;
	localparam int RUN_MAX = 18;

	localparam int BIN_W   = 32;
	localparam int BCD_DIG = 10;
	localparam int BCD_W   = 4 * BCD_DIG;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_UPA  = 8'd55;
	localparam logic [7:0] ASCII_LOWA = 8'd87;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_MINUS,
		PFX_HEX,
		PFX_NIL
	} pfx_t;

	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
		logic [BCD_W-1:0] r;
		r = b;
		for (int d = 0; d < BCD_DIG; d++) begin
			if (b[4*d +: 4] >= 4'd5)
				r[4*d +: 4] = b[4*d +: 4] + 4'd3;
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
		logic [7:0] r;
		if (n < 4'd10)
			r = ASCII_ZERO + {4'b0, n};
		else if (upper)
			r = ASCII_UPA + {4'b0, n};
		else
			r = ASCII_LOWA + {4'b0, n};
		return r;
	endfunction

	function automatic logic [2:0] prefix_len(input pfx_t k);
		logic [2:0] r;
		case (k)
			PFX_MINUS: r = 3'd1;
			PFX_HEX:   r = 3'd2;
			PFX_NIL:   r = 3'd5;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] prefix_char(input pfx_t k, input logic [2:0] i);
		logic [7:0] r;
		case (k)
			PFX_MINUS: r = 8'h2D;
			PFX_HEX:   r = (i == 3'd0) ? 8'h30 : 8'h78;
			PFX_NIL: begin
				case (i)
					3'd0:    r = 8'h28;
					3'd1:    r = 8'h6E;
					3'd2:    r = 8'h69;
					3'd3:    r = 8'h6C;
					default: r = 8'h29;
				endcase
			end
			default:   r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[hdl/integer_to_ascii_formatter_unit.sv]
// Integer to ASCII formatter: one number in, its characters out, one per word.
// First character: hex and pointer values first skip leading zero nibbles, a null pointer
// goes straight to its prefix, decimal first runs a shift-add-3 conversion of the low 32 bits.
// One item at a time: the input stalls until its last character word is issued; with
// out_stall low, one character word per cycle.
// Reset (arst_n low) clears the sequencer and the output valid at once.
module integer_to_ascii_formatter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [itoaf_pkg::ACT_W-1:0]   action,
	input  logic [itoaf_pkg::VALUE_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [itoaf_pkg::CHAR_W-1:0]  char_byte,
	output logic [itoaf_pkg::POS_W-1:0]   position,
	output logic                          last
);
	import itoaf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic                 out_valid_q;
	logic [BIN_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [VALUE_W-1:0]   dig_q;
	logic [4:0]           ndig_q;
	logic [4:0]           cnt_q;
	pfx_t                 kind_q;
	logic                 upper_q;
	logic [2:0]           pre_idx_q;
	logic [POS_W-1:0]     pos_q;
	logic [CHAR_W-1:0]    char_q;
	logic [POS_W-1:0]     position_q;
	logic                 last_q;

	logic                 in_go;
	logic                 emit_go;
	logic                 pre_active;
	logic                 emit_last;
	logic [CHAR_W-1:0]    emit_char;
	logic [BCD_W-1:0]     bcd_adj;
	logic [BCD_W-1:0]     bcd_next;
	logic [BIN_W-1:0]     low;
	logic [BIN_W-1:0]     neg_mag;
	logic                 skip_go;
	logic                 neg_in;
	logic                 nil_in;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_go      = in_valid && !in_stall;
	assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign pre_active = (pre_idx_q < prefix_len(kind_q));
	assign emit_last  = pre_active ? ((pre_idx_q == prefix_len(kind_q) - 3'd1) && (ndig_q == 5'd0))
	                               : (ndig_q == 5'd1);
	assign emit_char  = pre_active ? prefix_char(kind_q, pre_idx_q)
	                               : hex_char(dig_q[VALUE_W-1 -: 4], upper_q);
	assign bcd_adj    = bcd_adjust(bcd_q);
	assign bcd_next   = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
	assign low        = value[BIN_W-1:0];
	assign neg_mag    = BIN_W'(~low + 32'd1);
	assign skip_go    = (dig_q[VALUE_W-1 -: 4] == 4'd0) && (ndig_q > 5'd1);
	assign neg_in     = (action == ACT_SDEC) && low[BIN_W-1];
	assign nil_in     = (action == ACT_PTR) && (value == '0);

	assign out_valid = out_valid_q;
	assign char_byte = char_q;
	assign position  = position_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_go) begin
						case (action)
							ACT_SDEC, ACT_UDEC: state_q <= ST_DABBLE;
							ACT_HEXL, ACT_HEXU: state_q <= ST_SKIP;
							ACT_PTR:            state_q <= (value == '0) ? ST_EMIT : ST_SKIP;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DABBLE: begin
					if (cnt_q == 5'd31)
						state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (!skip_go)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go && emit_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cnt_q     <= 5'd0;
				pre_idx_q <= 3'd0;
				pos_q     <= '0;
				bcd_q     <= '0;
				upper_q   <= (action == ACT_HEXU);
				dig_q     <= value;
				ndig_q    <= nil_in ? 5'd0 : 5'd16;
				bin_q     <= neg_in ? neg_mag : low;
				if (neg_in)
					kind_q <= PFX_MINUS;
				else if (action == ACT_PTR)
					kind_q <= nil_in ? PFX_NIL : PFX_HEX;
				else
					kind_q <= PFX_NONE;
			end
			ST_DABBLE: begin
				bcd_q <= bcd_next;
				bin_q <= {bin_q[BIN_W-2:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					dig_q  <= {bcd_next, {(VALUE_W - BCD_W){1'b0}}};
					ndig_q <= 5'(BCD_DIG);
				end
			end
			ST_SKIP: begin
				if (skip_go) begin
					dig_q  <= {dig_q[VALUE_W-5:0], 4'b0};
					ndig_q <= ndig_q - 5'd1;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					char_q     <= emit_char;
					position_q <= pos_q;
					last_q     <= emit_last;
					pos_q      <= pos_q + 5'd1;
					if (pre_active) begin
						pre_idx_q <= pre_idx_q + 3'd1;
					end else begin
						dig_q  <= {dig_q[VALUE_W-5:0], 4'b0};
						ndig_q <= ndig_q - 5'd1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

[hdl/itoaf_chk.sv]
// Port-level checker for integer_to_ascii_formatter_unit, attached by bind.
// Depends on itoaf_pkg for field widths and the longest run.
module itoaf_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [itoaf_pkg::CHAR_W-1:0]  char_byte,
	input logic [itoaf_pkg::POS_W-1:0]   position,
	input logic                          last
);
	import itoaf_pkg::*;

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_byte) && $stable(position)
		&& $stable(last))
		else $error("stalled output word changed");

	// advance position within a run without gaps
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && position == $past(position) + 5'd1)
		else $error("run broken or position skipped");

	a_pos_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position < POS_W'(RUN_MAX))
		else $error("position beyond longest run");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken during a run");

endmodule

bind integer_to_ascii_formatter_unit itoaf_chk u_itoaf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.char_byte (char_byte),
	.position  (position),
	.last      (last)
);

[sim/tb_integer_to_ascii_formatter_unit.sv]
// Testbench for integer_to_ascii_formatter_unit: drives numbers with a format mode
// and checks every character word against a local formatter model.
// Depends on itoaf_pkg and the formatter unit; uses valid/stall handshakes on both sides.
module tb_integer_to_ascii_formatter_unit;
	import itoaf_pkg::*;

	localparam logic [2:0] ACT_BAD_LO = 3'd5;
	localparam int RANDOM_NUMBERS = 460;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [ACT_W-1:0]   act;
		logic [VALUE_W-1:0] val;
	} number_t;

	typedef struct {
		logic [CHAR_W-1:0] chr;
		logic [POS_W-1:0]  pos;
		logic              fin;
	} char_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ACT_W-1:0]     action = '0;
	logic [VALUE_W-1:0]   value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CHAR_W-1:0]    char_byte;
	logic [POS_W-1:0]     position;
	logic                 last;

	number_t number_queue[$];
	char_t   char_expect[$];
	char_t   want;
	int      numbers_taken = 0;
	int      err_count = 0;
	logic    calm;

	integer_to_ascii_formatter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_byte (char_byte),
		.position  (position),
		.last      (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	assign calm = (numbers_taken >= 200) && (numbers_taken < 300);

	function automatic void log_error(input string msg);
		if (err_count < 10)
			$display("mismatch: %s", msg);
		err_count++;
	endfunction

	function automatic void predict_chars(input logic [ACT_W-1:0] act,
			input logic [VALUE_W-1:0] val);
		byte unsigned txt[$];
		byte unsigned digs[$];
		logic [63:0] num;
		logic [31:0] mag32;
		logic [3:0]  nib;
		logic        is_dec;
		logic        hex_up;
		logic        ok;
		logic        nil;
		char_t       c;
		is_dec = 1'b0;
		hex_up = 1'b0;
		ok = 1'b1;
		nil = 1'b0;
		num = val;
		case (act)
			ACT_SDEC: begin
				is_dec = 1'b1;
				num = {32'b0, val[31:0]};
				if (val[31]) begin
					txt.push_back("-");
					mag32 = ~val[31:0] + 32'd1;
					num = {32'b0, mag32};
				end
			end
			ACT_UDEC: begin
				is_dec = 1'b1;
				num = {32'b0, val[31:0]};
			end
			ACT_HEXL: num = val;
			ACT_HEXU: begin
				num = val;
				hex_up = 1'b1;
			end
			ACT_PTR: begin
				if (val == 64'd0) begin
					nil = 1'b1;
					txt.push_back("(");
					txt.push_back("n");
					txt.push_back("i");
					txt.push_back("l");
					txt.push_back(")");
				end else begin
					txt.push_back("0");
					txt.push_back("x");
				end
			end
			default: ok = 1'b0;
		endcase
		if (!ok)
			return;
		if (!nil) begin
			for (int k = 0; k == 0 || num != 64'd0; k++) begin
				if (is_dec) begin
					digs.push_front(ASCII_ZERO + 8'(num % 64'd10));
					num = num / 64'd10;
				end else begin
					nib = num[3:0];
					num = num >> 4;
					if (nib < 4'd10)
						digs.push_front(ASCII_ZERO + {4'b0, nib});
					else if (hex_up)
						digs.push_front(ASCII_UPA + {4'b0, nib});
					else
						digs.push_front(ASCII_LOWA + {4'b0, nib});
				end
			end
			foreach (digs[i])
				txt.push_back(digs[i]);
		end
		foreach (txt[i]) begin
			c.chr = txt[i];
			c.pos = i[POS_W-1:0];
			c.fin = (i == txt.size() - 1);
			char_expect.push_back(c);
		end
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(6))
			0: v = v;
			1: v = 64'($urandom_range(20));
			2: v = v >> $urandom_range(63);
			3: v = 64'd1 << $urandom_range(63);
			4: v = {v[63:32], 32'h8000_0000 + 32'($urandom_range(3)) - 32'd1};
			5: v = ~(v >> $urandom_range(63));
			default: v = {v[63:32], 32'($urandom_range(1_000_000))};
		endcase
		return v;
	endfunction

	task automatic queue_number(input logic [ACT_W-1:0] act, input logic [VALUE_W-1:0] val);
		number_t n;
		n.act = act;
		n.val = val;
		number_queue.push_back(n);
	endtask

	always @(posedge clk or negedge arst_n) begin
		number_t n;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= '0;
			value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_chars(action, value);
				numbers_taken <= numbers_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (number_queue.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
					n = number_queue.pop_front();
					in_valid <= 1'b1;
					action <= n.act;
					value <= n.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (char_expect.size() == 0) begin
					log_error($sformatf("unexpected word char=%h pos=%0d last=%b",
						char_byte, position, last));
				end else begin
					want = char_expect.pop_front();
					if (char_byte !== want.chr || position !== want.pos || last !== want.fin)
						log_error($sformatf(
							"expected char=%h pos=%0d last=%b, got char=%h pos=%0d last=%b",
							want.chr, want.pos, want.fin, char_byte, position, last));
				end
			end
			out_stall <= !calm && ($urandom_range(99) < 13);
		end
	end

	initial begin
		int made;
		logic [ACT_W-1:0] act;
		queue_number(ACT_SDEC, 64'd0);
		queue_number(ACT_SDEC, 64'd1);
		queue_number(ACT_SDEC, 64'h1234_5678_FFFF_FFFF);
		queue_number(ACT_SDEC, 64'h0000_0000_8000_0000);
		queue_number(ACT_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
		queue_number(ACT_SDEC, 64'hFFFF_FFFF_0000_3039);
		queue_number(ACT_UDEC, 64'd0);
		queue_number(ACT_UDEC, 64'h0000_0000_FFFF_FFFF);
		queue_number(ACT_UDEC, 64'hFFFF_FFFF_0000_0000);
		queue_number(ACT_UDEC, 64'd10);
		queue_number(ACT_HEXL, 64'd0);
		queue_number(ACT_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(ACT_HEXL, 64'h0123_4567_89AB_CDEF);
		queue_number(ACT_HEXL, 64'hA);
		queue_number(ACT_HEXU, 64'd0);
		queue_number(ACT_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(ACT_HEXU, 64'hFEDC_BA98_7654_3210);
		queue_number(ACT_PTR, 64'd0);
		queue_number(ACT_PTR, 64'd1);
		queue_number(ACT_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(ACT_PTR, 64'h8000_0000_0000_0000);
		queue_number(ACT_BAD_LO, 64'h1234);
		queue_number(ACT_BAD_LO + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(ACT_BAD_LO + 3'd2, 64'd0);
		made = 0;
		while (made < RANDOM_NUMBERS) begin
			if ($urandom_range(99) < 5)
				act = ACT_BAD_LO + 3'($urandom_range(2));
			else
				act = 3'($urandom_range(4));
			queue_number(act, rand_value());
			if (act <= ACT_PTR)
				made++;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (number_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (char_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (char_expect.size() != 0)
			log_error($sformatf("%0d characters never arrived", char_expect.size()));
		if (err_count == 0)
			$display("tb_integer_to_ascii_formatter_unit: PASS");
		else
			$display("tb_integer_to_ascii_formatter_unit: FAIL");
		$finish;
	end

	initial begin
		#400000;
		$display("tb_integer_to_ascii_formatter_unit: FAIL");
		$finish;
	end

endmodule
